### rtl/core/bce_pkg.sv
// Package with constants, types and helper functions of the contour extraction block.
`timescale 1ns / 1ps

package bce_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);

   localparam int PIXEL_W     = 8;
   localparam int LIMIT_W     = 4;
   localparam int CFG_COLS_W  = 11;
   localparam int CFG_ROWS_W  = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_GREY_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOUR_LIM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLUMNS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS     = 3'd3;

   localparam logic [PIXEL_W-1:0]    RST_THRESHOLD = 8'd200;
   localparam logic [LIMIT_W-1:0]    RST_LIMIT     = 4'd1;
   localparam logic [CFG_COLS_W-1:0] RST_COLUMNS   = 11'd640;
   localparam logic [CFG_ROWS_W-1:0] RST_ROWS      = 13'd480;

   localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'd0;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_pixel;
      logic [ROW_W-1:0]   out_row;
      logic [COL_W-1:0]   out_column;
      logic               last_of_run;
   } bce_result_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0]      valid;
      bce_result_type [MAX_RESULTS-1:0] item;
   } bce_push_type;

   function automatic logic [LIMIT_W-1:0] bce_popcount8(input logic [7:0] bits);
      logic [LIMIT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + LIMIT_W'(bits[i]);
      end
      return n;
   endfunction

endpackage

### rtl/core/bce_channels.sv
// Handshake channel interfaces for pixel input, result output and register writes.
`timescale 1ns / 1ps

interface bce_pixel_if;
   import bce_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] grey_pixel;
   modport source (output valid, output grey_pixel, input ready);
   modport sink (input valid, input grey_pixel, output ready);
endinterface

interface bce_result_if;
   import bce_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_pixel;
   logic [ROW_W-1:0]   out_row;
   logic [COL_W-1:0]   out_column;
   logic               last_of_run;
   modport source (output valid, output out_pixel, output out_row, output out_column,
                   output last_of_run, input ready);
   modport sink (input valid, input out_pixel, input out_row, input out_column,
                 input last_of_run, output ready);
endinterface

interface bce_csr_if;
   import bce_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/bce_rsp_queue.sv
// Result queue that takes up to three result words per cycle and hands them out one at a time.
`timescale 1ns / 1ps

module bce_rsp_queue
   import bce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  bce_push_type        push,
   output logic [QUEUE_CW-1:0] fill,
   bce_result_if.source        rsp_chan
);

   bce_result_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    head_ff;
   logic [QUEUE_AW-1:0]    head_in;
   logic [QUEUE_AW-1:0]    tail_ff;
   logic [QUEUE_AW-1:0]    tail_in;
   logic [QUEUE_CW-1:0]    count_ff;
   logic [QUEUE_CW-1:0]    count_in;
   logic [QUEUE_AW-1:0]    slot [MAX_RESULTS];
   logic [QUEUE_CW-1:0]    n_push;
   logic                   pop;
   bce_result_type         head_word;

   always_comb begin
      slot[0] = tail_ff;
      slot[1] = tail_ff + QUEUE_AW'(push.valid[0]);
      slot[2] = tail_ff + QUEUE_AW'(push.valid[0]) + QUEUE_AW'(push.valid[1]);
      n_push  = QUEUE_CW'(push.valid[0]) + QUEUE_CW'(push.valid[1])
              + QUEUE_CW'(push.valid[2]);
      pop      = rsp_chan.valid && rsp_chan.ready;
      head_in  = head_ff + QUEUE_AW'(pop);
      tail_in  = tail_ff + n_push[QUEUE_AW-1:0];
      count_in = count_ff + n_push - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (push.valid[k]) begin
            entry_ff[slot[k]] <= push.item[k];
         end
      end
   end

   assign head_word            = entry_ff[head_ff];
   assign fill                 = count_ff;
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_pixel   = head_word.out_pixel;
   assign rsp_chan.out_row     = head_word.out_row;
   assign rsp_chan.out_column  = head_word.out_column;
   assign rsp_chan.last_of_run = head_word.last_of_run;

endmodule

### rtl/core/binary_contour_extract_3x3.sv
// Results of a word pass through the s1 stage register and are then written into the output queue.
// Throughput: one pixel word per cycle while the result side keeps up; each word yields
// zero to three result words, so the last row runs at the rate the result side drains.
// The line memory is read in the accept cycle and written back in the cycle after it.
// Synchronous reset clears the counters, window, queue and registers to reset values;
// the line memory is not cleared and holds unknown bits until written.
`timescale 1ns / 1ps

module binary_contour_extract_3x3
   import bce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bce_pixel_if.sink   req_chan,
   bce_result_if.source rsp_chan,
   bce_csr_if.sink     csr_chan
);

   typedef struct packed {
      logic             t;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      logic             e_mid;
      logic             e_interior;
      logic             e_right;
      logic             e_bottom;
      logic             fwd;
      logic [1:0]       fwd_data;
   } bce_stage_type;

   logic [PIXEL_W-1:0]    threshold_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [CFG_COLS_W-1:0] columns_ff;
   logic [CFG_ROWS_W-1:0] rows_ff;

   logic [1:0]       line_mem_ff [MAX_COLUMNS];
   logic [1:0]       line_q_ff;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [8:0]       window_ff;
   logic [8:0]       window_in;
   logic             s1_valid_ff;
   logic [1:0]       s1_count_ff;
   logic [1:0]       s1_count_in;
   bce_stage_type    s1_ff;
   bce_stage_type    s1_in;

   logic [CFG_COLS_W-1:0] cols_sat;
   logic [CFG_ROWS_W-1:0] rows_sat;
   logic                  accept;
   logic                  col_wrap;
   logic [COL_W-1:0]      c0;
   logic [CFG_ROWS_W-1:0] row_inc;
   logic [ROW_W-1:0]      r0;
   logic [CFG_COLS_W-1:0] c_next;
   logic [CFG_ROWS_W-1:0] r_next;
   logic                  last_col;
   logic                  last_row;

   logic [1:0]            line_rd;
   logic [1:0]            line_wr;
   logic [2:0]            new_col;
   logic                  center;
   logic [LIMIT_W-1:0]    n_white;
   logic                  mid_white;
   logic [QUEUE_CW-1:0]   fill;
   logic [QUEUE_CW+1:0]   need;
   bce_push_type          push;

   always_comb begin
      cols_sat = columns_ff;
      if (columns_ff == '0) begin
         cols_sat = CFG_COLS_W'(1);
      end else if (columns_ff > CFG_COLS_W'(MAX_COLUMNS)) begin
         cols_sat = CFG_COLS_W'(MAX_COLUMNS);
      end
      rows_sat = rows_ff;
      if (rows_ff == '0) begin
         rows_sat = CFG_ROWS_W'(1);
      end else if (rows_ff > CFG_ROWS_W'(MAX_ROWS)) begin
         rows_sat = CFG_ROWS_W'(MAX_ROWS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_THRESHOLD;
         limit_ff     <= RST_LIMIT;
         columns_ff   <= RST_COLUMNS;
         rows_ff      <= RST_ROWS;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_GREY_THRESHOLD: threshold_ff <= csr_chan.data[PIXEL_W-1:0];
            CSR_NEIGHBOUR_LIM:  limit_ff     <= csr_chan.data[LIMIT_W-1:0];
            CSR_IMAGE_COLUMNS:  columns_ff   <= csr_chan.data[CFG_COLS_W-1:0];
            CSR_IMAGE_ROWS:     rows_ff      <= csr_chan.data[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // The next word may come only if the queue can take its results and those in flight.
   assign need           = (QUEUE_CW+2)'(fill) + (QUEUE_CW+2)'(s1_count_ff)
                         + (QUEUE_CW+2)'(MAX_RESULTS);
   assign req_chan.ready = (need <= (QUEUE_CW+2)'(QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      col_wrap = ({1'b0, col_ff} >= cols_sat);
      c0       = col_wrap ? '0 : col_ff;
      row_inc  = {1'b0, row_ff} + CFG_ROWS_W'(col_wrap);
      r0       = (row_inc >= rows_sat) ? '0 : row_inc[ROW_W-1:0];
      c_next   = {1'b0, c0} + CFG_COLS_W'(1);
      r_next   = {1'b0, r0} + CFG_ROWS_W'(1);
      last_col = (c_next == cols_sat);
      last_row = (r_next == rows_sat);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : r_next[ROW_W-1:0];
         end else begin
            col_in = c_next[COL_W-1:0];
            row_in = r0;
         end
      end
   end

   always_comb begin
      s1_in.t          = (req_chan.grey_pixel > threshold_ff);
      s1_in.r          = r0;
      s1_in.c          = c0;
      s1_in.e_mid      = (r0 != '0) && (c0 != '0);
      s1_in.e_interior = (r0 > ROW_W'(1)) && (c0 > COL_W'(1));
      s1_in.e_right    = (r0 != '0) && last_col;
      s1_in.e_bottom   = last_row;
      s1_in.fwd        = s1_valid_ff && (s1_ff.c == c0);
      s1_in.fwd_data   = line_wr;
      s1_count_in      = 2'(s1_in.e_mid) + 2'(s1_in.e_right) + 2'(s1_in.e_bottom);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_count_ff <= '0;
         window_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         s1_count_ff <= accept ? s1_count_in : 2'd0;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Each entry holds the bit two rows up in bit 1 and the bit one row up in bit 0.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem_ff[s1_ff.c] <= line_wr;
      end
      if (accept) begin
         line_q_ff <= line_mem_ff[c0];
      end
   end

   always_comb begin
      line_rd   = s1_ff.fwd ? s1_ff.fwd_data : line_q_ff;
      line_wr   = {line_rd[0], s1_ff.t};
      new_col   = {line_rd[1], line_rd[0], s1_ff.t};
      window_in = s1_valid_ff ? {window_ff[5:0], new_col} : window_ff;
      center    = window_in[4];
      n_white   = bce_popcount8({window_in[8:5], window_in[3:0]});
      mid_white = center || (s1_ff.e_interior && (n_white < limit_ff));
   end

   always_comb begin
      push.valid[0] = s1_valid_ff && s1_ff.e_mid;
      push.valid[1] = s1_valid_ff && s1_ff.e_right;
      push.valid[2] = s1_valid_ff && s1_ff.e_bottom;

      push.item[0].out_pixel   = mid_white ? PIXEL_WHITE : PIXEL_BLACK;
      push.item[0].out_row     = s1_ff.r - ROW_W'(1);
      push.item[0].out_column  = s1_ff.c - COL_W'(1);
      push.item[0].last_of_run = !s1_ff.e_right && !s1_ff.e_bottom;

      push.item[1].out_pixel   = line_rd[0] ? PIXEL_WHITE : PIXEL_BLACK;
      push.item[1].out_row     = s1_ff.r - ROW_W'(1);
      push.item[1].out_column  = s1_ff.c;
      push.item[1].last_of_run = !s1_ff.e_bottom;

      push.item[2].out_pixel   = s1_ff.t ? PIXEL_WHITE : PIXEL_BLACK;
      push.item[2].out_row     = s1_ff.r;
      push.item[2].out_column  = s1_ff.c;
      push.item[2].last_of_run = 1'b1;
   end

   bce_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fill     (fill),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/core/bce_checker.sv
// Port-level checker for the contour extraction block and its bind to the top level.
`timescale 1ns / 1ps

module bce_checker
   import bce_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_out_pixel,
   input logic [ROW_W-1:0]   rsp_out_row,
   input logic [COL_W-1:0]   rsp_out_column,
   input logic               rsp_last_of_run
);

   // After reset the result queue is empty.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   // A result pixel is always pure black or pure white.
   a_binary_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_pixel == PIXEL_BLACK || rsp_out_pixel == PIXEL_WHITE))
      else $error("result pixel is neither black nor white");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_pixel) && $stable(rsp_out_row)
         && $stable(rsp_out_column) && $stable(rsp_last_of_run))
      else $error("result word changed while stalled");

endmodule

bind binary_contour_extract_3x3 bce_checker u_bce_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_pixel   (rsp_chan.out_pixel),
   .rsp_out_row     (rsp_chan.out_row),
   .rsp_out_column  (rsp_chan.out_column),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

### tb/tb.sv
// Self-checking testbench for the 3x3 binary contour extraction block.
`timescale 1ns / 1ps

module tb;
   import bce_pkg::*;

   localparam int IDLE_PCT      = 9;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 16;
   localparam int MAX_REPORTS   = 50;
   localparam int PRIME_COLUMNS = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPARE = CSR_IMAGE_ROWS + CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_SPARE  = '1;

   localparam logic [PIXEL_W-1:0] SAMPLE_FRAME [20] = '{
      8'd0,   8'd255, 8'd100, 8'd101, 8'd0,
      8'd255, 8'd0,   8'd0,   8'd0,   8'd255,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd255
   };

   logic clock = 1'b1;
   logic reset = 1'b1;

   bce_pixel_if  req_chan ();
   bce_result_if rsp_chan ();
   bce_csr_if    csr_chan ();

   binary_contour_extract_3x3 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [PIXEL_W-1:0]    threshold_reg = RST_THRESHOLD;
   logic [LIMIT_W-1:0]    limit_reg     = RST_LIMIT;
   logic [CFG_COLS_W-1:0] columns_reg   = RST_COLUMNS;
   logic [CFG_ROWS_W-1:0] rows_reg      = RST_ROWS;
   logic                  upper_line [MAX_COLUMNS] = '{default: 1'b0};
   logic                  middle_line [MAX_COLUMNS] = '{default: 1'b0};
   logic [8:0]            window = '0;
   int unsigned           row_pos = 0;
   int unsigned           col_pos = 0;

   bce_result_type     expected_pixels [$];
   logic [PIXEL_W-1:0] pending_grey [$];
   int                 pixels_sent = 0;
   int                 pixels_accepted = 0;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   logic               pixel_taken = 1'b0;
   logic               csr_taken = 1'b0;
   logic               idle_enable = 1'b1;
   int                 hold_requests = 0;
   int                 holds_served = 0;
   int                 hold_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bce_result_type result_word(input logic white, input int unsigned r,
                                                  input int unsigned c);
      bce_result_type word;
      word.out_pixel   = white ? PIXEL_WHITE : PIXEL_BLACK;
      word.out_row     = ROW_W'(r);
      word.out_column  = COL_W'(c);
      word.last_of_run = 1'b0;
      return word;
   endfunction

   function automatic void predict_contour(input logic [PIXEL_W-1:0] grey);
      int unsigned    cols, rows, r, c, n;
      logic           t, px;
      logic [2:0]     column_bits;
      bce_result_type run [MAX_RESULTS];
      cols = (columns_reg == 0) ? 1 : (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : columns_reg;
      rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      n = 0;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= rows) row_pos = 0;
      r = row_pos;
      c = col_pos;
      t = grey > threshold_reg;
      column_bits = {upper_line[c], middle_line[c], t};
      window = {window[5:0], column_bits};
      upper_line[c] = middle_line[c];
      middle_line[c] = t;
      if (r >= 1 && c >= 1) begin
         px = window[4];
         if (r >= 2 && c >= 2 && !window[4] && $countones(window) < limit_reg) px = 1'b1;
         run[n] = result_word(px, r - 1, c - 1);
         n++;
      end
      if (r >= 1 && c == cols - 1) begin
         run[n] = result_word(column_bits[1], r - 1, c);
         n++;
      end
      if (r == rows - 1) begin
         run[n] = result_word(t, r, c);
         n++;
      end
      if (n > 0) run[n - 1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) expected_pixels.push_back(run[k]);
      col_pos++;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= rows) row_pos = 0;
      end
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
   endtask

   always @(posedge clock) begin : watch_channels
      bce_result_type want;
      cycle_count++;
      pixel_taken <= req_chan.valid && req_chan.ready;
      csr_taken <= csr_chan.valid && csr_chan.ready;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_GREY_THRESHOLD: threshold_reg = csr_chan.data[PIXEL_W-1:0];
               CSR_NEIGHBOUR_LIM: limit_reg = csr_chan.data[LIMIT_W-1:0];
               CSR_IMAGE_COLUMNS: columns_reg = csr_chan.data[CFG_COLS_W-1:0];
               CSR_IMAGE_ROWS: rows_reg = csr_chan.data[CFG_ROWS_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_contour(req_chan.grey_pixel);
            pixels_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected word, out_row", rsp_chan.out_row, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.out_pixel !== want.out_pixel)
                  report_mismatch("out_pixel", rsp_chan.out_pixel, want.out_pixel);
               if (rsp_chan.out_row !== want.out_row)
                  report_mismatch("out_row", rsp_chan.out_row, want.out_row);
               if (rsp_chan.out_column !== want.out_column)
                  report_mismatch("out_column", rsp_chan.out_column, want.out_column);
               if (rsp_chan.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_chan.last_of_run, want.last_of_run);
            end
         end
      end
   end

   always @(negedge clock) begin : drive_pixels
      logic offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || pixel_taken) begin
         offer = pending_grey.size() != 0 && !(idle_enable && $urandom_range(99) < IDLE_PCT);
         if (offer) req_chan.grey_pixel <= pending_grey.pop_front();
         req_chan.valid <= offer;
      end
   end

   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [PIXEL_W-1:0] random_grey(input int white_pct);
      if ($urandom_range(9) == 0) return PIXEL_W'($urandom);
      if ($urandom_range(99) < white_pct && threshold_reg != PIXEL_WHITE)
         return PIXEL_W'($urandom_range(PIXEL_WHITE, threshold_reg + 1));
      return PIXEL_W'($urandom_range(threshold_reg, 0));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] grey);
      pending_grey.push_back(grey);
      pixels_sent++;
   endtask

   task automatic send_random(input int count, input int white_pct);
      for (int i = 0; i < count; i++) send_pixel(random_grey(white_pct));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pixels_accepted != pixels_sent || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Bits above the register width carry random data and must be ignored.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value,
                                 input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = CSR_DATA_W'((1 << width) - 1);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(value) & mask);
      do @(negedge clock);
      while (!csr_taken);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic write_spare();
      write_register(CSR_IDX_W'($urandom_range(CSR_LAST_SPARE, CSR_FIRST_SPARE)), $urandom, 0);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int random_left, frame_cols, frame_rows, count;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A few words at the reset geometry stay in the first row.
      send_random(4, 50);
      wait_drained();

      // Oversized columns and zero rows saturate to one long row.
      idle_enable = 1'b0;
      write_register(CSR_IMAGE_COLUMNS, 2047, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 0, CFG_ROWS_W);
      send_random(8, 50);
      wait_drained();

      // Every line entry that later frames use gets written twice.
      write_register(CSR_IMAGE_COLUMNS, PRIME_COLUMNS, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 1, CFG_ROWS_W);
      send_random(2 * PRIME_COLUMNS, 50);
      wait_drained();
      idle_enable = 1'b1;

      write_spare();
      write_register(CSR_GREY_THRESHOLD, 100, PIXEL_W);
      write_register(CSR_IMAGE_COLUMNS, 5, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 4, CFG_ROWS_W);
      foreach (SAMPLE_FRAME[i]) send_pixel(SAMPLE_FRAME[i]);
      wait_drained();

      for (int tc = 0; tc < 3; tc++) begin
         for (int tr = 0; tr < 3; tr++) begin
            write_register(CSR_IMAGE_COLUMNS, tc, CFG_COLS_W);
            write_register(CSR_IMAGE_ROWS, tr, CFG_ROWS_W);
            send_random($urandom_range(3, 2), 50);
            wait_drained();
         end
      end

      write_register(CSR_IMAGE_COLUMNS, 6, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 5, CFG_ROWS_W);
      write_register(CSR_NEIGHBOUR_LIM, 0, LIMIT_W);
      send_random(8, 30);
      wait_drained();
      write_register(CSR_NEIGHBOUR_LIM, 9, LIMIT_W);
      send_random(8, 40);
      wait_drained();
      write_register(CSR_NEIGHBOUR_LIM, 15, LIMIT_W);
      write_register(CSR_GREY_THRESHOLD, 255, PIXEL_W);
      send_random(8, 30);
      wait_drained();

      // Geometry changes while a frame is in progress.
      write_register(CSR_GREY_THRESHOLD, 128, PIXEL_W);
      write_register(CSR_NEIGHBOUR_LIM, 3, LIMIT_W);
      write_register(CSR_IMAGE_COLUMNS, 8, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 6, CFG_ROWS_W);
      send_random(10, 40);
      wait_drained();
      write_register(CSR_IMAGE_COLUMNS, 3, CFG_COLS_W);
      send_random(6, 40);
      wait_drained();
      write_register(CSR_IMAGE_ROWS, 2, CFG_ROWS_W);
      send_random(6, 40);
      wait_drained();
      write_register(CSR_IMAGE_COLUMNS, 10, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 5, CFG_ROWS_W);
      send_random(10, 40);
      wait_drained();

      // Saturated row count with a long result-side hold at the start.
      write_register(CSR_GREY_THRESHOLD, 0, PIXEL_W);
      write_register(CSR_IMAGE_COLUMNS, 1, CFG_COLS_W);
      write_register(CSR_IMAGE_ROWS, 8191, CFG_ROWS_W);
      hold_requests++;
      send_random(16, 50);
      wait_drained();

      random_left = RANDOM_ITEMS;
      while (random_left > 0) begin
         frame_cols = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
         frame_rows = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(5, 3);
         write_register(CSR_IMAGE_COLUMNS, frame_cols, CFG_COLS_W);
         write_register(CSR_IMAGE_ROWS, frame_rows, CFG_ROWS_W);
         write_register(CSR_GREY_THRESHOLD, $urandom_range(255), PIXEL_W);
         write_register(CSR_NEIGHBOUR_LIM, $urandom_range(15), LIMIT_W);
         if ($urandom_range(3) == 0) write_spare();
         count = (frame_cols < 1 ? 1 : frame_cols) * (frame_rows < 1 ? 1 : frame_rows);
         if ($urandom_range(3) == 0) count = $urandom_range(count, 1);
         idle_enable = $urandom_range(4) != 0;
         send_random(count, $urandom_range(70, 10));
         random_left -= count;
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
